/* rtl/core/adc_conversion_scheduler_assert.svh */
// Assertion helpers for the conversion scheduler.
// They sample on clk and are disabled while rst_n is low.
`ifndef ADC_CONVERSION_SCHEDULER_ASSERT_SVH
`define ADC_CONVERSION_SCHEDULER_ASSERT_SVH

// Same-cycle implication
`define ACS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/acs_pkg.sv */
`default_nettype none

package acs_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam int SLOT_W        = 3;
    localparam int CHAN_W        = 8;
    localparam int OP_W          = 3;
    localparam int KIND_W        = 2;
    localparam int EV_W          = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_REQUEST    = 3'd0;
    localparam logic [OP_W-1:0] OP_FAST_START = 3'd1;
    localparam logic [OP_W-1:0] OP_FAST_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_DONE       = 3'd3;
    localparam logic [OP_W-1:0] OP_FAIL       = 3'd4;
    localparam logic [OP_W-1:0] OP_COLLECT    = 3'd5;
    localparam logic [OP_W-1:0] OP_MISSED     = 3'd6;

    // Start kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SLOW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAST = 2'd2;

    // Stream event bits
    localparam logic [EV_W-1:0] EV_RUNNING = 4'b0001;
    localparam logic [EV_W-1:0] EV_GOTBUF  = 4'b0010;
    localparam logic [EV_W-1:0] EV_LOST    = 4'b0100;
    localparam logic [EV_W-1:0] EV_STALL   = 4'b1000;

    typedef struct packed {
        logic              capture;
        logic              exec;
        logic              emit;
        logic              coll_step;
        logic [SLOT_W-1:0] idx;
    } acs_cmd_t;

    typedef struct packed {
        logic collect_op;
        logic fin_none;
        logic coll_last;
    } acs_stat_t;

endpackage

`default_nettype wire

/* rtl/core/acs_ctrl.sv */
`default_nettype none

module acs_ctrl #(
    parameter int SLOTS = acs_pkg::SLOTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire acs_pkg::acs_stat_t stat,
    output acs_pkg::acs_cmd_t      cmd
);
    import acs_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_COLL = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.coll_step = 1'b0;
        cmd.idx       = SLOT_W'(idx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                idx_next = '0;
                if (stat.collect_op && !stat.fin_none)
                    state_next = ST_COLL;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COLL:
            begin
                cmd.coll_step = 1'b1;
                if (stat.coll_last)
                    state_next = ST_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/core/acs_datapath.sv */
`default_nettype none

module acs_datapath #(
    parameter int SLOTS = acs_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire acs_pkg::acs_cmd_t            cmd,
    output acs_pkg::acs_stat_t                stat,
    input  wire logic                         cfg_write,
    input  wire logic [acs_pkg::CHAN_W-1:0]   cfg_data,
    input  wire logic [acs_pkg::OP_W-1:0]     operation,
    input  wire logic [acs_pkg::CHAN_W-1:0]   channel,
    input  wire logic                         buffer_available,
    input  wire logic                         buffer_has_data,
    output logic                              result_valid,
    output logic [acs_pkg::KIND_W-1:0]        start_kind,
    output logic [acs_pkg::CHAN_W-1:0]        start_channel,
    output logic [acs_pkg::SLOT_W-1:0]        start_slot,
    output logic                              start_immediately,
    output logic                              request_accepted,
    output logic                              buffer_queued,
    output logic                              buffer_returned,
    output logic [acs_pkg::EV_W-1:0]          event_bits,
    output logic                              finished_valid,
    output logic [acs_pkg::SLOT_W-1:0]        finished_slot,
    output logic                              converter_busy,
    output logic                              last
);
    import acs_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (v[i])
                r = IDX_W'(i);
        return r;
    endfunction

    // Captured event
    logic [OP_W-1:0]    op_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic               avail_reg;
    logic               has_data_reg;

    // Scheduler state
    logic [CHAN_W-1:0]  fast_channel_reg;
    logic [SLOTS-1:0]   active_reg, done_reg, fin_reg;
    logic [IDX_W-1:0]   cur_slot_reg;
    logic               cur_is_reg, busy_reg, fa_reg, stall_reg, hold_reg, miss_reg;
    logic [EV_W-1:0]    ev_reg;

    // Slot channel store
    logic [CHAN_W-1:0]  chan_mem [SLOTS];
    logic [CHAN_W-1:0]  mem_q;

    // Next values from the execute step
    logic [SLOTS-1:0]   active_next, done_next, fin_next;
    logic [IDX_W-1:0]   cur_slot_next;
    logic               cur_is_next, busy_next, fa_next, stall_next, hold_next, miss_next;
    logic [EV_W-1:0]    ev_next;
    logic [SLOTS-1:0]   pend, after_mask, first_mask, above_mask;
    logic [SLOTS-1:0]   free_vec;
    logic [IDX_W-1:0]   free_idx, cidx;
    logic               mem_we, accepted, queued, returned, do_sched, now;
    logic [KIND_W-1:0]  kind;

    // Output registers
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic [SLOT_W-1:0]  out_slot_reg, out_fs_reg;
    logic               out_now_reg, out_acc_reg, out_q_reg, out_ret_reg;
    logic [EV_W-1:0]    out_ev_reg;
    logic               out_fv_reg, out_cb_reg, out_last_reg;

    assign free_vec = ~active_reg;
    assign free_idx = first_set(free_vec);
    assign cidx     = cmd.idx[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            after_mask[i] = !cur_is_reg || (IDX_W'(i) > cur_slot_reg);
            above_mask[i] = (IDX_W'(i) > cidx);
        end
    end

    always_comb
    begin
        active_next   = active_reg;
        done_next     = done_reg;
        fin_next      = '0;
        cur_slot_next = cur_slot_reg;
        cur_is_next   = cur_is_reg;
        busy_next     = busy_reg;
        fa_next       = fa_reg;
        stall_next    = stall_reg;
        hold_next     = hold_reg;
        miss_next     = miss_reg;
        ev_next       = ev_reg;
        mem_we        = 1'b0;
        accepted      = 1'b0;
        queued        = 1'b0;
        returned      = 1'b0;
        do_sched      = 1'b0;
        now           = 1'b0;
        kind          = KIND_NONE;

        case (op_reg)
            OP_REQUEST:
            begin
                if (|free_vec)
                begin
                    mem_we                = 1'b1;
                    active_next[free_idx] = 1'b1;
                    done_next[free_idx]   = 1'b0;
                    accepted              = 1'b1;
                    do_sched              = !busy_reg;
                end
            end
            OP_FAST_START:
            begin
                if (!fa_reg)
                begin
                    fa_next    = 1'b1;
                    stall_next = 1'b0;
                    do_sched   = !busy_reg;
                end
            end
            OP_FAST_STOP:
            begin
                if (fa_reg)
                begin
                    fa_next    = 1'b0;
                    stall_next = 1'b0;
                    if (hold_reg)
                    begin
                        hold_next = 1'b0;
                        returned  = 1'b1;
                    end
                    do_sched = !busy_reg || !cur_is_reg;
                end
            end
            OP_DONE:
            begin
                if (cur_is_reg)
                begin
                    if (active_reg[cur_slot_reg])
                        done_next[cur_slot_reg] = 1'b1;
                end
                else if (fa_reg && hold_reg)
                begin
                    hold_next = 1'b0;
                    if (has_data_reg)
                    begin
                        queued  = 1'b1;
                        ev_next = EV_RUNNING | EV_GOTBUF
                                | (miss_reg ? EV_LOST : '0)
                                | (stall_reg ? EV_STALL : '0);
                    end
                    else
                    begin
                        returned = 1'b1;
                    end
                end
                do_sched = 1'b1;
            end
            OP_FAIL:
            begin
                // failed slot stays pending and is retried on a later pass
                do_sched = 1'b1;
            end
            OP_COLLECT:
            begin
                fin_next    = active_reg & done_reg;
                active_next = active_reg & ~fin_next;
                done_next   = done_reg & ~fin_next;
            end
            OP_MISSED:
            begin
                miss_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        pend       = active_next & ~done_next;
        first_mask = pend & after_mask;

        if (do_sched)
        begin
            busy_next = 1'b1;
            if (|first_mask)
            begin
                cur_is_next   = 1'b1;
                cur_slot_next = first_set(first_mask);
                kind          = KIND_SLOW;
            end
            else
            begin
                cur_is_next = 1'b0;
                if (fa_next)
                begin
                    if (hold_next || avail_reg)
                    begin
                        hold_next  = 1'b1;
                        now        = miss_next || stall_next;
                        stall_next = 1'b0;
                        miss_next  = 1'b0;
                        kind       = KIND_FAST;
                    end
                    else
                    begin
                        // stall: drop running flag and rescan from slot 0
                        stall_next = 1'b1;
                        ev_next    = ev_next & ~EV_RUNNING;
                        if (|pend)
                        begin
                            cur_is_next   = 1'b1;
                            cur_slot_next = first_set(pend);
                            kind          = KIND_SLOW;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    assign stat.collect_op = (op_reg == OP_COLLECT);
    assign stat.fin_none   = ((active_reg & done_reg) == '0);
    assign stat.coll_last  = (fin_reg[cidx] && !(|(fin_reg & above_mask)))
                           || (cidx == IDX_W'(SLOTS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            chan_reg     <= channel;
            avail_reg    <= buffer_available;
            has_data_reg <= buffer_has_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fast_channel_reg <= '0;
        else if (cfg_write)
            fast_channel_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            done_reg     <= '0;
            fin_reg      <= '0;
            cur_slot_reg <= '0;
            cur_is_reg   <= 1'b0;
            busy_reg     <= 1'b0;
            fa_reg       <= 1'b0;
            stall_reg    <= 1'b0;
            hold_reg     <= 1'b0;
            miss_reg     <= 1'b0;
            ev_reg       <= '0;
        end
        else if (cmd.exec)
        begin
            active_reg   <= active_next;
            done_reg     <= done_next;
            fin_reg      <= fin_next;
            cur_slot_reg <= cur_slot_next;
            cur_is_reg   <= cur_is_next;
            busy_reg     <= busy_next;
            fa_reg       <= fa_next;
            stall_reg    <= stall_next;
            hold_reg     <= hold_next;
            miss_reg     <= miss_next;
            ev_reg       <= ev_next;
        end
    end

    // One write and one registered read; a request may schedule its own slot
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (mem_we)
                chan_mem[free_idx] <= chan_reg;
            if (mem_we && (free_idx == cur_slot_next))
                mem_q <= chan_reg;
            else
                mem_q <= chan_mem[cur_slot_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (cmd.coll_step)
            out_valid_reg <= fin_reg[cidx];
        else
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_kind_reg <= kind;
            out_slot_reg <= (kind == KIND_SLOW) ? SLOT_W'(cur_slot_next) : '0;
            out_now_reg  <= now;
            out_acc_reg  <= accepted;
            out_q_reg    <= queued;
            out_ret_reg  <= returned;
            out_ev_reg   <= ev_next;
            out_fv_reg   <= 1'b0;
            out_fs_reg   <= '0;
            out_cb_reg   <= busy_next;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            case (out_kind_reg)
                KIND_SLOW: out_chan_reg <= mem_q;
                KIND_FAST: out_chan_reg <= fast_channel_reg;
                default:   out_chan_reg <= '0;
            endcase
        end
        else if (cmd.coll_step)
        begin
            out_kind_reg <= KIND_NONE;
            out_chan_reg <= '0;
            out_slot_reg <= '0;
            out_now_reg  <= 1'b0;
            out_acc_reg  <= 1'b0;
            out_q_reg    <= 1'b0;
            out_ret_reg  <= 1'b0;
            out_ev_reg   <= ev_reg;
            out_fv_reg   <= 1'b1;
            out_fs_reg   <= SLOT_W'(cidx);
            out_cb_reg   <= busy_reg;
            out_last_reg <= stat.coll_last;
        end
    end

    assign result_valid      = out_valid_reg;
    assign start_kind        = out_kind_reg;
    assign start_channel     = out_chan_reg;
    assign start_slot        = out_slot_reg;
    assign start_immediately = out_now_reg;
    assign request_accepted  = out_acc_reg;
    assign buffer_queued     = out_q_reg;
    assign buffer_returned   = out_ret_reg;
    assign event_bits        = out_ev_reg;
    assign finished_valid    = out_fv_reg;
    assign finished_slot     = out_fs_reg;
    assign converter_busy    = out_cb_reg;
    assign last              = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/adc_conversion_scheduler.sv */
// Converter scheduler. An event is taken when start is high and busy is low;
// it is captured, executed in one step and answered. Each result is shown for
// exactly one cycle under result_valid and cannot be held off, so the receiver
// must take it then; last marks the final result of an event. Every event but
// collect gives one result; the block is free again in the cycle that shows it.
// Collect walks the slots one per cycle, up to the highest finished one, and
// gives a result for each finished slot. fast_channel is to be written with
// cfg_write only while the block is idle; the block does not enforce this.
`default_nettype none

`include "adc_conversion_scheduler_assert.svh"

module adc_conversion_scheduler #(
    parameter int SLOTS = acs_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cfg_write,
    input  wire logic [acs_pkg::CHAN_W-1:0]   cfg_data,
    input  wire logic [acs_pkg::OP_W-1:0]     operation,
    input  wire logic [acs_pkg::CHAN_W-1:0]   channel,
    input  wire logic                         buffer_available,
    input  wire logic                         buffer_has_data,
    output logic                              result_valid,
    output logic [acs_pkg::KIND_W-1:0]        start_kind,
    output logic [acs_pkg::CHAN_W-1:0]        start_channel,
    output logic [acs_pkg::SLOT_W-1:0]        start_slot,
    output logic                              start_immediately,
    output logic                              request_accepted,
    output logic                              buffer_queued,
    output logic                              buffer_returned,
    output logic [acs_pkg::EV_W-1:0]          event_bits,
    output logic                              finished_valid,
    output logic [acs_pkg::SLOT_W-1:0]        finished_slot,
    output logic                              converter_busy,
    output logic                              last
);
    import acs_pkg::*;

    acs_cmd_t  cmd;
    acs_stat_t stat;

    acs_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    acs_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write         (cfg_write),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .channel           (channel),
        .buffer_available  (buffer_available),
        .buffer_has_data   (buffer_has_data),
        .result_valid      (result_valid),
        .start_kind        (start_kind),
        .start_channel     (start_channel),
        .start_slot        (start_slot),
        .start_immediately (start_immediately),
        .request_accepted  (request_accepted),
        .buffer_queued     (buffer_queued),
        .buffer_returned   (buffer_returned),
        .event_bits        (event_bits),
        .finished_valid    (finished_valid),
        .finished_slot     (finished_slot),
        .converter_busy    (converter_busy),
        .last              (last)
    );

    // The final result of an event frees the block; earlier ones keep it busy
    `ACS_ASSERT_SAME(a_last_frees, result_valid && last, !busy, "last result while busy")
    `ACS_ASSERT_SAME(a_more_busy, result_valid && !last, busy, "result ends event early")
    // Freed-slot reports start nothing
    `ACS_ASSERT_SAME(a_fin_kind, result_valid && finished_valid,
        start_kind == KIND_NONE, "collect result starts a conversion")
    // A started conversion leaves the converter busy
    `ACS_ASSERT_SAME(a_start_busy, result_valid && (start_kind != KIND_NONE),
        converter_busy, "conversion started with converter idle")
    // Accepting an event raises busy before any result of it is shown
    `ACS_ASSERT_NEXT(a_no_early, start && !busy, busy && !result_valid, "early result")

endmodule

`default_nettype wire
